// ----- hdl/slnt_pkg.sv -----
// Package: command/status codes and payload types for the sorted leaf node table.
`timescale 1ns / 1ps
package slnt_pkg;

    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_LOCATE = 3'd2;
    localparam logic [2:0] CMD_READ   = 3'd3;
    localparam logic [2:0] CMD_SPLIT  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NO_REC  = 2'd2;
    localparam logic [1:0] ST_REFUSED = 2'd3;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] key;
        logic [30:0]        rid_page;
        logic [30:0]        rid_slot;
        logic [6:0]         entry_index;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [6:0]         found_index;
        logic signed [31:0] out_key;
        logic [30:0]        out_rid_page;
        logic [30:0]        out_rid_slot;
        logic [6:0]         entry_count;
        logic               last;
    } t_out;

    // one table entry as stored in memory
    typedef struct packed {
        logic signed [31:0] key;
        logic [30:0]        page;
        logic [30:0]        slot;
    } t_entry;

endpackage

// ----- hdl/sorted_leaf_node_table.sv -----
// Top level: sorted B+ tree leaf table held in one synchronous entry memory.
`timescale 1ns / 1ps
// Sorted leaf table: entries live in a single-port-read, single-port-write
// memory with a registered read; a sequencer walks it one entry at a time.
// Clear, full-insert, out-of-range read and refused commands present their
// result in the cycle after the transaction is taken; a valid read passes
// through S_READ and S_OUT first. Locate scans from entry 0, reading then
// comparing each entry, until the first key >= the search key or the end of
// the entries. Insert scans the same way, then shifts the tail up one
// entry per cycle. Insert-split reads the first upper key, sets count to
// (count+1)/2, places the new key in the lower half if it belongs there,
// then streams the upper half, one transaction per cycle while i_ready is
// high, with a bubble through S_READ where the new key merges into the upper
// half. One command is handled at a time; the next is taken only when the
// block is idle and its last result has been accepted.
module sorted_leaf_node_table #(
    parameter int CAPACITY = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  slnt_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output slnt_pkg::t_out o_data
);
    import slnt_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam logic [6:0] CAP7  = 7'(CAPACITY);
    localparam logic [6:0] HALF7 = 7'((CAPACITY + 1) / 2);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;  // read issued at r_ptr
    localparam logic [3:0] S_SHIFT = 4'd2;  // moving entry r_ptr-1 to r_ptr
    localparam logic [3:0] S_READ  = 4'd3;
    localparam logic [3:0] S_EMIT  = 4'd4;
    localparam logic [3:0] S_OUT   = 4'd5;  // single result waiting
    localparam logic [3:0] S_SPLIT = 4'd6;  // streaming upper half
    localparam logic [3:0] S_SWAIT = 4'd7;  // insert: prime read of r_ptr-1; split: emitting new key in upper half

    // entry memory
    t_entry r_mem [CAPACITY];
    t_entry r_rd;
    logic   mem_we;
    logic [IW-1:0] mem_wa, mem_ra;
    t_entry mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[mem_ra];
    end

    logic [3:0]   r_state;
    logic [6:0]   r_count;
    logic [6:0]   r_ptr;       // scan / shift / stream position
    logic [6:0]   r_pos;       // insertion point
    logic         r_ins_done;  // split: new key already emitted
    logic         r_ins_low;   // split: new key goes to lower half
    logic         r_lowpass;   // split: doing lower-half insert first
    t_entry       r_sep;       // split: first upper entry, before any shift
    t_in          r_cmd;
    t_out         r_out;
    logic         r_ovalid;

    function automatic logic key_lt(logic signed [31:0] a, logic signed [31:0] b);
        return a < b;
    endfunction

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    t_entry new_ent;
    assign new_ent = '{key: r_cmd.key, page: r_cmd.rid_page, slot: r_cmd.rid_slot};

    // a lower-half insert may overwrite the first upper slot, so stream it from r_sep
    t_entry split_ent;
    assign split_ent = (r_ins_low && r_ptr == HALF7) ? r_sep : r_rd;

    // memory port drive
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_ptr[IW-1:0];
        mem_wd = r_rd;
        mem_ra = r_ptr[IW-1:0];
        unique case (r_state)
            S_SHIFT: begin
                if (r_ptr > r_pos) begin
                    mem_we = 1'b1;
                    mem_wd = r_rd;
                    mem_ra = IW'(r_ptr - 7'd2);
                end else begin
                    mem_we = 1'b1;
                    mem_wd = new_ent;
                end
            end
            S_SWAIT: mem_ra = IW'(r_ptr - 7'd1);
            // hold the read address while the output is stalled
            S_SPLIT: mem_ra = (!r_ovalid || i_ready) ? IW'(r_ptr + 7'd1) : r_ptr[IW-1:0];
            default: ;
        endcase
    end

    function automatic t_out mk(logic [1:0] st, logic [6:0] fi, t_entry e,
                                logic [6:0] cnt, logic lst);
        t_out o;
        o.status = st; o.found_index = fi; o.out_key = e.key;
        o.out_rid_page = e.page; o.out_rid_slot = e.slot;
        o.entry_count = cnt; o.last = lst;
        return o;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_ptr    <= '0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_cmd <= i_data;
                        r_ptr <= '0;
                        r_lowpass <= 1'b0;
                        r_ins_done <= 1'b0;
                        unique case (i_data.cmd)
                            CMD_CLEAR: begin
                                r_count <= '0;
                                r_out <= mk(ST_OK, '0, '0, '0, 1'b1);
                                r_ovalid <= 1'b1;
                            end
                            CMD_INSERT: begin
                                if (r_count >= CAP7) begin
                                    r_out <= mk(ST_FULL, '0, '0, r_count, 1'b1);
                                    r_ovalid <= 1'b1;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            CMD_LOCATE: r_state <= S_SCAN;
                            CMD_READ: begin
                                if (i_data.entry_index >= r_count) begin
                                    r_out <= mk(ST_NO_REC, '0, '0, r_count, 1'b1);
                                    r_ovalid <= 1'b1;
                                end else begin
                                    r_ptr <= i_data.entry_index;
                                    r_state <= S_READ;
                                end
                            end
                            CMD_SPLIT: begin
                                if (r_count < CAP7) begin
                                    r_out <= mk(ST_REFUSED, '0, '0, r_count, 1'b1);
                                    r_ovalid <= 1'b1;
                                end else begin
                                    // read first upper key to pick the side
                                    r_ptr <= HALF7;
                                    r_state <= S_SCAN;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ: begin
                    if (r_cmd.cmd == CMD_SPLIT) begin
                        // re-read after emitting the merged new key in the upper half
                        r_lowpass <= 1'b0;
                        r_state <= S_SPLIT;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_out <= mk(ST_OK, '0, r_rd, r_count, 1'b1);
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    // r_ptr entry being read; data arrives next cycle
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (r_cmd.cmd == CMD_SPLIT && !r_lowpass) begin
                        // r_rd holds first upper entry
                        r_count <= HALF7;
                        r_sep <= r_rd;
                        if (key_lt(r_cmd.key, r_rd.key)) begin
                            r_ins_low <= 1'b1;
                            r_lowpass <= 1'b1;
                            r_ptr <= '0;
                            r_state <= S_SCAN;
                        end else begin
                            r_ins_low <= 1'b0;
                            r_ptr <= HALF7;
                            r_state <= S_SPLIT;
                        end
                    end else if (r_ptr < r_count && key_lt(r_rd.key, r_cmd.key)) begin
                        r_ptr <= r_ptr + 7'd1;
                        r_state <= S_SCAN;
                    end else if (r_cmd.cmd == CMD_LOCATE) begin
                        r_out <= mk((r_ptr < r_count && r_rd.key == r_cmd.key)
                                    ? ST_OK : ST_NO_REC, r_ptr, '0, r_count, 1'b1);
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        // insert: shift tail from count down to pos
                        r_pos <= r_ptr;
                        r_ptr <= r_count;
                        r_state <= (r_count > r_ptr) ? S_SWAIT : S_SHIFT;
                    end
                end
                S_SWAIT: begin
                    // prime read of entry ptr-1
                    if (r_cmd.cmd == CMD_SPLIT && !r_lowpass) begin
                        // upper-half new key emission
                        if (!r_ovalid || i_ready) begin
                            r_out <= mk(ST_OK, '0, new_ent, r_count,
                                        r_ptr == CAP7);
                            r_ovalid <= 1'b1;
                            r_ins_done <= 1'b1;
                            r_state <= (r_ptr == CAP7) ? S_IDLE : S_SPLIT;
                        end
                    end else begin
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (r_ptr > r_pos) begin
                        r_ptr <= r_ptr - 7'd1;
                    end else begin
                        r_count <= r_count + 7'd1;
                        if (r_lowpass) begin
                            r_lowpass <= 1'b0;
                            r_ptr <= HALF7;
                            r_state <= S_SPLIT;
                        end else begin
                            r_out <= mk(ST_OK, '0, '0, r_count + 7'd1, 1'b1);
                            r_ovalid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_SPLIT: begin
                    // r_rd holds entry r_ptr (read issued last cycle)
                    if (!r_ovalid || i_ready) begin
                        if (!r_ins_low && !r_ins_done && !key_lt(r_rd.key, r_cmd.key)) begin
                            // new key precedes this entry: re-read it later
                            r_out <= mk(ST_OK, '0, new_ent, r_count, 1'b0);
                            r_ovalid <= 1'b1;
                            r_ins_done <= 1'b1;
                            r_state <= S_READ;
                            r_cmd.cmd <= CMD_SPLIT;
                            r_lowpass <= 1'b1;
                        end else begin
                            r_out <= mk(ST_OK, '0, split_ent, r_count,
                                        r_ptr == CAP7 - 7'd1 && (r_ins_low || r_ins_done));
                            r_ovalid <= 1'b1;
                            r_ptr <= r_ptr + 7'd1;
                            if (r_ptr == CAP7 - 7'd1) begin
                                if (r_ins_low || r_ins_done) r_state <= S_IDLE;
                                else begin
                                    r_ptr <= CAP7;
                                    r_state <= S_SWAIT;
                                end
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- hdl/slnt_checker.sv -----
// Checker: port-level properties of the sorted leaf node table, with bind.
`timescale 1ns / 1ps
module slnt_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_valid,
    input logic           o_ready,
    input slnt_pkg::t_in  i_data,
    input logic           o_valid,
    input logic           i_ready,
    input slnt_pkg::t_out o_data
);
    import slnt_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result dropped or changed while stalled");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.entry_count <= 7'd127)
        else $error("entry count out of range");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("accepted a command with a result pending");

    // a taken clear answers next cycle with an empty, final result
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_data.cmd == CMD_CLEAR
        |=> o_valid && o_data.status == ST_OK && o_data.entry_count == 7'd0
            && o_data.last)
        else $error("bad clear result");
endmodule

bind sorted_leaf_node_table slnt_checker u_slnt_checker (.*);
